// ----- hw/rtl/old_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// old_pkg
// Shared codes, field widths and control bundles for the ordered list engine.
// ----------------------------------------------------------------------------
package old_pkg;

    localparam int LIST_DEPTH_DEF = 16;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_CLEAR       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_HEAD = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_TAIL = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_MATCH = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic                latch;      // capture the item's value
        logic                pos_zero;   // position <- head
        logic                pos_tail;   // position <- count - 1
        logic                pos_inc;    // position <- position + 1
        logic                rd_next;    // read at position + 1 instead of position
        logic                wr_append;  // write item value at count
        logic                wr_shift;   // write read data at position
        logic                clear;      // count <- 0
        logic                count_inc;
        logic                count_dec;
        logic                res_load;   // load result registers
        logic [STATUS_W-1:0] res_status;
        logic                res_take;   // removed value <- read data, else zero
    } old_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic hit;        // read data equals item value
        logic last;       // position is the last element
        logic next_last;  // position + 1 is the last element
    } old_stat_t;

endpackage

// ----- hw/rtl/old_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// old_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module old_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/old_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// old_datapath
// List storage, element count, scan position and result registers.
// ----------------------------------------------------------------------------
module old_datapath #(
    parameter int LIST_DEPTH = old_pkg::LIST_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  old_pkg::old_cmd_t                 cmd,
    output old_pkg::old_stat_t                st,
    input  logic signed [old_pkg::VALUE_W-1:0] value_in,
    output logic [old_pkg::STATUS_W-1:0]      status,
    output logic signed [old_pkg::VALUE_W-1:0] removed_value,
    output logic [old_pkg::COUNT_W-1:0]       count
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic [CW-1:0]                 pos_reg;
    logic [CW-1:0]                 pos_next;
    logic [CW-1:0]                 pos_p1;
    logic [CW:0]                   pos_p2;
    logic [old_pkg::VALUE_W-1:0]   value_reg;
    logic [old_pkg::STATUS_W-1:0]  status_reg;
    logic [old_pkg::VALUE_W-1:0]   removed_reg;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [AW-1:0]                 ram_raddr;
    logic [old_pkg::VALUE_W-1:0]   ram_wdata;
    logic [old_pkg::VALUE_W-1:0]   ram_rdata;

    assign pos_p1 = pos_reg + CW'(1);
    assign pos_p2 = {1'b0, pos_reg} + (CW+1)'(2);

    assign st.empty     = (count_reg == '0);
    assign st.full      = (count_reg >= CW'(LIST_DEPTH));
    assign st.hit       = (ram_rdata == value_reg);
    assign st.last      = (pos_p1 >= count_reg);
    assign st.next_last = (pos_p2 >= {1'b0, count_reg});

    // storage: append writes at the tail, shift moves element pos+1 down to pos
    assign ram_we    = cmd.wr_append | cmd.wr_shift;
    assign ram_waddr = cmd.wr_append ? count_reg[AW-1:0] : pos_reg[AW-1:0];
    assign ram_wdata = cmd.wr_append ? value_in : ram_rdata;
    assign ram_raddr = cmd.rd_next ? pos_p1[AW-1:0] : pos_reg[AW-1:0];

    old_ram #(
        .WIDTH (old_pkg::VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        priority if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end

        pos_next = pos_reg;
        priority if (cmd.pos_zero)
        begin
            pos_next = '0;
        end
        else if (cmd.pos_tail)
        begin
            pos_next = count_reg - CW'(1);
        end
        else if (cmd.pos_inc)
        begin
            pos_next = pos_p1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            value_reg <= value_in;
        end
        if (cmd.res_load)
        begin
            status_reg  <= cmd.res_status;
            removed_reg <= cmd.res_take ? ram_rdata : '0;
        end
    end

    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign count         = old_pkg::COUNT_W'(count_reg);

endmodule

// ----- hw/rtl/old_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// old_ctrl
// Sequencer: decodes the action, steps the scan and the gap-closing shift.
// ----------------------------------------------------------------------------
module old_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [old_pkg::ACTION_W-1:0]  action,
    output logic                          out_valid,
    input  logic                          out_ready,
    output old_pkg::old_cmd_t             cmd,
    input  old_pkg::old_stat_t            st
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SHRD,
        S_SHWR,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   match_reg;   // search for a value rather than a fixed position
    logic   match_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        match_next = match_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch      = 1'b1;
                    cmd.res_status = old_pkg::ST_OK;
                    state_next     = S_OUT;
                    unique case (action)
                        old_pkg::ACT_CLEAR:
                        begin
                            cmd.clear    = 1'b1;
                            cmd.res_load = 1'b1;
                        end
                        old_pkg::ACT_APPEND:
                        begin
                            cmd.res_load = 1'b1;
                            if (st.full)
                            begin
                                cmd.res_status = old_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.wr_append = 1'b1;
                                cmd.count_inc = 1'b1;
                            end
                        end
                        old_pkg::ACT_REMOVE_HEAD,
                        old_pkg::ACT_REMOVE_TAIL,
                        old_pkg::ACT_REMOVE_MATCH:
                        begin
                            if (st.empty)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = old_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_RD;
                                match_next = (action == old_pkg::ACT_REMOVE_MATCH);
                                if (action == old_pkg::ACT_REMOVE_TAIL)
                                begin
                                    cmd.pos_tail = 1'b1;
                                end
                                else
                                begin
                                    cmd.pos_zero = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            // undefined action: no change, plain ok result
                            cmd.res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (match_reg && !st.hit)
                begin
                    if (st.last)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = old_pkg::ST_NOT_FOUND;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        cmd.pos_inc = 1'b1;
                        state_next  = S_RD;
                    end
                end
                else
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = old_pkg::ST_OK;
                    cmd.res_take   = 1'b1;
                    if (st.last)
                    begin
                        cmd.count_dec = 1'b1;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SHRD;
                    end
                end
            end
            S_SHRD:
            begin
                cmd.rd_next = 1'b1;
                state_next  = S_SHWR;
            end
            S_SHWR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.pos_inc  = 1'b1;
                if (st.next_last)
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    state_next = S_SHRD;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            match_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            match_reg <= match_next;
        end
    end

endmodule

// ----- hw/rtl/ordered_list_delete_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_delete_engine
// Ordered list of signed values with append, head/tail/match removal, clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, action, value) takes one request per
//   transfer; output channel (out_valid/out_ready, status, removed_value,
//   count) returns exactly one result per request, in order.
//   One request is in flight at a time; in_ready is high only while idle.
//   Clear, append, refused and undefined actions go straight to the result.
//   Removals read, then compare, each scanned element in turn (S_RD, S_CMP);
//   a match scan that misses steps on until the last element and then reports
//   not found. Once an element other than the last is removed, each element
//   after it is read and then written one position down (S_SHRD, S_SHWR).
//   The single-port-read RAM is why each element is read before it is
//   compared or moved. in_ready is back in the cycle after the output
//   transfer. Reset empties the list (count zero); RAM contents are not
//   cleared, since only entries below the count are ever read.
//   While out_ready is low the result is held steady and no request is taken.
// ----------------------------------------------------------------------------
module ordered_list_delete_engine #(
    parameter int LIST_DEPTH = old_pkg::LIST_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [old_pkg::ACTION_W-1:0]       action,
    input  logic signed [old_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [old_pkg::STATUS_W-1:0]       status,
    output logic signed [old_pkg::VALUE_W-1:0] removed_value,
    output logic [old_pkg::COUNT_W-1:0]        count
);

    old_pkg::old_cmd_t  cmd;
    old_pkg::old_stat_t st;

    // sequencer: decode, scan and shift stepping
    old_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .st        (st)
    );

    // storage, count, position and result registers
    old_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .value_in      (value),
        .status        (status),
        .removed_value (removed_value),
        .count         (count)
    );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered list delete engine.
// ----------------------------------------------------------------------------
// A short directed run covers the empty-list refusals, undefined actions,
// extreme values, duplicate matches and a miss. Random segments follow, each
// biased to fill, drain or mix the list, with values mostly taken from a
// small pool so that match removals hit often and the full list is reached.
// A behavioral copy of the list, kept in a queue, predicts each result when
// the request transfer happens; the monitor compares results in order.
// Both channels idle and stall at random, with some quiet segments.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ACTION_W     = old_pkg::ACTION_W;
    localparam int VALUE_W      = old_pkg::VALUE_W;
    localparam int STATUS_W     = old_pkg::STATUS_W;
    localparam int COUNT_W      = old_pkg::COUNT_W;

    localparam int LIST_DEPTH   = old_pkg::LIST_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1250;
    localparam int TAIL_CYCLES  = 2 * LIST_DEPTH + 10;   // worst scan plus margin
    localparam int CYCLE_LIMIT  = 500000;
    localparam int POOL_SIZE    = 8;
    localparam int MAX_PRINTS   = 100;

    // codes 5..7 are not actions; the block must treat them as no-ops
    localparam logic [ACTION_W-1:0] ACT_UNDEF_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNDEF_LAST  = 3'd7;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef enum int { SEG_FILL, SEG_DRAIN, SEG_MIXED } seg_mode_t;

    typedef struct {
        logic [ACTION_W-1:0]       act;
        logic signed [VALUE_W-1:0] val;
        int unsigned               gap;   // idle cycles before this request
    } request_t;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] removed;
        logic [COUNT_W-1:0]        count;
    } list_result_t;

    // DUT signals; every input has a known value from time zero
    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic [ACTION_W-1:0]        action    = old_pkg::ACT_CLEAR;
    logic signed [VALUE_W-1:0]  value     = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  removed_value;
    logic [COUNT_W-1:0]         count;

    // stimulus and prediction state
    request_t                  requests_todo[$];
    list_result_t              results_due[$];
    logic signed [VALUE_W-1:0] list_model[$];
    logic signed [VALUE_W-1:0] value_pool[POOL_SIZE];
    bit                        gen_quiet;

    // driver state
    request_t    held_req;
    bit          held_waiting = 1'b0;
    int unsigned gap_left;

    // monitor state
    int unsigned stall_left;
    bit          out_quiet;

    int mismatches  = 0;
    int cycles      = 0;
    int act_seen[8];
    int status_seen[4];
    int results_seen = 0;

    ordered_list_delete_engine #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .removed_value (removed_value),
        .count         (count)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] ERROR: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // List behavior: apply one action to the queue copy, return the result
    // ------------------------------------------------------------------------
    function automatic list_result_t apply_to_list(input logic [ACTION_W-1:0] act,
                                                   input logic signed [VALUE_W-1:0] val);
        list_result_t r;
        int           hit_pos;
        r.status  = old_pkg::ST_OK;
        r.removed = '0;
        hit_pos   = -1;
        case (act)
            old_pkg::ACT_CLEAR: list_model.delete();
            old_pkg::ACT_APPEND:
            begin
                if (list_model.size() >= LIST_DEPTH)
                    r.status = old_pkg::ST_FULL;
                else
                    list_model.push_back(val);
            end
            old_pkg::ACT_REMOVE_HEAD:
            begin
                if (list_model.size() == 0)
                    r.status = old_pkg::ST_EMPTY;
                else
                    r.removed = list_model.pop_front();
            end
            old_pkg::ACT_REMOVE_TAIL:
            begin
                if (list_model.size() == 0)
                    r.status = old_pkg::ST_EMPTY;
                else
                    r.removed = list_model.pop_back();
            end
            old_pkg::ACT_REMOVE_MATCH:
            begin
                if (list_model.size() == 0)
                begin
                    r.status = old_pkg::ST_EMPTY;
                end
                else
                begin
                    // first match wins; later duplicates stay in place
                    foreach (list_model[i])
                        if (hit_pos < 0 && list_model[i] == val)
                            hit_pos = i;
                    if (hit_pos < 0)
                    begin
                        r.status = old_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        r.removed = list_model[hit_pos];
                        list_model.delete(hit_pos);
                    end
                end
            end
            default: ;   // undefined codes leave the list alone
        endcase
        r.count = COUNT_W'(list_model.size());
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_request(input logic [ACTION_W-1:0] act,
                                          input logic signed [VALUE_W-1:0] val);
        request_t req;
        req.act = act;
        req.val = val;
        req.gap = gen_quiet ? 0 : $urandom_range(0, 9);
        requests_todo.push_back(req);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [ACTION_W-1:0] choose_action(input seg_mode_t mode);
        int t[5];
        int pick;
        pick = $urandom_range(0, 99);
        case (mode)
            SEG_FILL:  t = '{80, 88, 93, 97, 98};
            SEG_DRAIN: t = '{20, 50, 70, 90, 94};
            default:   t = '{45, 70, 82, 94, 97};
        endcase
        if (pick < t[0]) return old_pkg::ACT_APPEND;
        if (pick < t[1]) return old_pkg::ACT_REMOVE_MATCH;
        if (pick < t[2]) return old_pkg::ACT_REMOVE_HEAD;
        if (pick < t[3]) return old_pkg::ACT_REMOVE_TAIL;
        if (pick < t[4]) return old_pkg::ACT_CLEAR;
        return ACTION_W'($urandom_range(ACT_UNDEF_FIRST, ACT_UNDEF_LAST));
    endfunction

    // ------------------------------------------------------------------------
    // Driver: one request per transfer, with a drawn gap before each.
    // The expected result is computed at the transfer edge.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        request_t nxt;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            action       <= old_pkg::ACT_CLEAR;
            value        <= '0;
            gap_left     <= 0;
            held_waiting <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                results_due.push_back(apply_to_list(action, value));
                act_seen[action]++;
            end
            // channel free: either nothing offered or the offer just went through
            if (!in_valid || in_ready)
            begin
                if (held_waiting)
                begin
                    if (gap_left > 1)
                    begin
                        gap_left <= gap_left - 1;
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        action       <= held_req.act;
                        value        <= held_req.val;
                        in_valid     <= 1'b1;
                        held_waiting <= 1'b0;
                    end
                end
                else if (requests_todo.size() != 0)
                begin
                    nxt = requests_todo.pop_front();
                    if (nxt.gap == 0)
                    begin
                        action   <= nxt.act;
                        value    <= nxt.val;
                        in_valid <= 1'b1;
                    end
                    else
                    begin
                        held_req     <= nxt;
                        gap_left     <= nxt.gap;
                        held_waiting <= 1'b1;
                        in_valid     <= 1'b0;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compares each result transfer with the oldest expectation,
    // then holds out_ready low for a drawn number of cycles.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t exp_r;
        int unsigned  stall;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            out_quiet  <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                status_seen[status]++;
                if (results_due.size() == 0)
                begin
                    report_mismatch($sformatf("result with nothing pending: st=%0d rm=%0d cnt=%0d",
                                              status, removed_value, count));
                end
                else
                begin
                    exp_r = results_due.pop_front();
                    if (status !== exp_r.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  status, exp_r.status));
                    if (removed_value !== exp_r.removed)
                        report_mismatch($sformatf("removed_value %0d, want %0d",
                                                  removed_value, exp_r.removed));
                    if (count !== exp_r.count)
                        report_mismatch($sformatf("count %0d, want %0d",
                                                  count, exp_r.count));
                end
                // re-pick the stall style every 64 results
                if (results_seen % 64 == 0)
                    out_quiet <= ($urandom_range(0, 3) == 0);
                stall      = out_quiet ? 0 : $urandom_range(0, 9);
                stall_left <= stall;
                out_ready  <= (stall == 0);
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= (stall_left == 1);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycles, results_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        seg_mode_t mode;
        int        seg_len;
        int        counted;
        logic [ACTION_W-1:0] a;

        counted   = 0;
        gen_quiet = 1'b0;

        // directed: refusals on an empty list, undefined codes, extremes,
        // a miss, a tail match, duplicates (first one goes), head and tail
        queue_request(old_pkg::ACT_REMOVE_HEAD,  32'sd0);
        queue_request(old_pkg::ACT_REMOVE_TAIL,  32'sd0);
        queue_request(old_pkg::ACT_REMOVE_MATCH, 32'sd0);
        queue_request(ACT_UNDEF_FIRST,           VAL_MAX);
        queue_request(old_pkg::ACT_CLEAR,        VAL_MIN);
        queue_request(old_pkg::ACT_APPEND,       VAL_MIN);
        queue_request(old_pkg::ACT_APPEND,       VAL_MAX);
        queue_request(old_pkg::ACT_APPEND,       32'sd0);
        queue_request(old_pkg::ACT_APPEND,       -32'sd1);
        queue_request(old_pkg::ACT_REMOVE_MATCH, 32'sd12345);
        queue_request(old_pkg::ACT_REMOVE_MATCH, -32'sd1);
        queue_request(old_pkg::ACT_APPEND,       -32'sd1);
        queue_request(old_pkg::ACT_APPEND,       VAL_MAX);
        queue_request(old_pkg::ACT_REMOVE_MATCH, VAL_MAX);
        queue_request(old_pkg::ACT_REMOVE_HEAD,  32'sd7);
        queue_request(old_pkg::ACT_REMOVE_TAIL,  32'sd7);
        queue_request(ACT_UNDEF_FIRST + 3'd1,    -32'sd1);
        queue_request(ACT_UNDEF_LAST,            VAL_MIN);
        queue_request(old_pkg::ACT_REMOVE_MATCH, VAL_MIN);
        queue_request(old_pkg::ACT_CLEAR,        32'sd0);
        queue_request(old_pkg::ACT_REMOVE_MATCH, 32'sd0);

        // random segments; undefined codes do not count toward the total
        while (counted < RANDOM_ITEMS)
        begin
            mode      = seg_mode_t'($urandom_range(0, 2));
            gen_quiet = ($urandom_range(0, 3) == 0);
            seg_len   = $urandom_range(25, 60);
            foreach (value_pool[i])
            begin
                case ($urandom_range(0, 9))
                    0:       value_pool[i] = VAL_MIN;
                    1:       value_pool[i] = VAL_MAX;
                    2:       value_pool[i] = -32'sd1;
                    default: value_pool[i] = $urandom;
                endcase
            end
            for (int k = 0; k < seg_len; k++)
            begin
                a = choose_action(mode);
                queue_request(a, pick_value());
                if (a <= old_pkg::ACT_REMOVE_MATCH)
                    counted++;
            end
        end

        // async reset, released away from the clock edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (requests_todo.size() != 0 || held_waiting || in_valid
               || results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", results_due.size()));

        $display("Transfers: clear %0d, append %0d, head %0d, tail %0d, match %0d, undefined %0d",
                 act_seen[old_pkg::ACT_CLEAR], act_seen[old_pkg::ACT_APPEND],
                 act_seen[old_pkg::ACT_REMOVE_HEAD], act_seen[old_pkg::ACT_REMOVE_TAIL],
                 act_seen[old_pkg::ACT_REMOVE_MATCH],
                 act_seen[ACT_UNDEF_FIRST] + act_seen[ACT_UNDEF_FIRST + 3'd1]
                 + act_seen[ACT_UNDEF_LAST]);
        $display("Results: %0d total; ok %0d, empty %0d, not found %0d, full %0d",
                 results_seen, status_seen[old_pkg::ST_OK], status_seen[old_pkg::ST_EMPTY],
                 status_seen[old_pkg::ST_NOT_FOUND], status_seen[old_pkg::ST_FULL]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
